// File: src/wgm_pkg.sv
package wgm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int NPOS        = MAX_PATTERN + 1;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 6;
  localparam int WORD_W      = 64;
  localparam int NWORDS      = 4;
  localparam int CHARS_PER_W = WORD_W / CHAR_W;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN = 3'd4;

  localparam logic [NPOS-1:0] START_SET = NPOS'(1);

  // Signals handed from one position cell to the next one up.
  typedef struct packed {
    logic carry;  // star closure: position i is active, so is i+1
    logic adv;    // position i consumed the character
  } wgm_link_t;

endpackage

// File: src/wgm_in_if.sv
interface wgm_in_if import wgm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] text_char;
  logic              has_char;
  logic              end_of_text;

  modport source (output valid, text_char, has_char, end_of_text, input ready);
  modport sink   (input valid, text_char, has_char, end_of_text, output ready);
endinterface

// File: src/wgm_out_if.sv
interface wgm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

// File: src/wgm_cfg_if.sv
interface wgm_cfg_if import wgm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/wgm_cell.sv
module wgm_cell import wgm_pkg::*; (
  input  logic              act,
  input  logic [CHAR_W-1:0] pat_char,
  input  logic              in_use,
  input  logic              in_range,
  input  logic [CHAR_W-1:0] text_char,
  input  wgm_link_t         link_in,
  output wgm_link_t         link_out,
  output logic              closed,
  output logic              nxt
);

  logic is_star;
  logic hit;

  assign is_star = (pat_char == STAR_CHAR);
  assign hit     = !is_star && ((pat_char == ANY_CHAR) || (pat_char == text_char));

  // Active after closure: own bit if in range, or reached across a star below.
  assign closed         = (act && in_range) || link_in.carry;
  assign link_out.carry = closed && in_use && is_star;
  assign link_out.adv   = closed && in_use && hit;
  // Star holds its position; a matching lower position advances into this one.
  assign nxt            = (closed && in_use && is_star) || link_in.adv;

endmodule

// File: src/wgm_row.sv
module wgm_row import wgm_pkg::*; (
  input  logic [NPOS-1:0]   act,
  input  logic [CHAR_W-1:0] pat_char [NPOS],
  input  logic [NPOS-1:0]   in_use,
  input  logic [NPOS-1:0]   in_range,
  input  logic [CHAR_W-1:0] text_char,
  output logic [NPOS-1:0]   nxt,
  output logic              tail
);

  wgm_link_t       link [NPOS+1];
  logic [NPOS-1:0] closed;

  assign link[0] = '0;

  for (genvar i = 0; i < NPOS; i++) begin : g_cell
    wgm_cell u_cell (
      .act       (act[i]),
      .pat_char  (pat_char[i]),
      .in_use    (in_use[i]),
      .in_range  (in_range[i]),
      .text_char (text_char),
      .link_in   (link[i]),
      .link_out  (link[i+1]),
      .closed    (closed[i]),
      .nxt       (nxt[i])
    );
  end

  // The last link leaves the row only from a position that is never in use.
  wgm_link_t unused_link;
  assign unused_link = link[NPOS];

  // Accept position is the one in range but not in use: exactly one bit.
  assign tail = |(closed & in_range & ~in_use) && !(unused_link.carry && unused_link.adv);

endmodule

// File: src/wildcard_glob_matcher_top.sv
// Channel  Dir  Payload                              Accepted when
// in_if    in   text_char[7:0] has_char end_of_text  in_if.valid && in_if.ready
// out_if   out  matched                              out_if.valid && out_if.ready
// cfg_if   in   index[2:0] data[63:0]                cfg_if.valid && cfg_if.ready
//
// One text item per cycle while in_if.ready is high. A row of 33 position cells ripples the star closure
// and the character step through the active set in the cycle the item arrives.
// An item ending a string parks its final set in a result stage; a second row
// closes it there, and the match bit moves into the output register once that
// register is empty or its result is taken.
// Reset (rst_n low, synchronous) clears the pattern and length to zero and sets
// the start position. A stalled output holds one result plus one in the result
// stage before in_if.ready drops. cfg_if.ready is always high.
module wildcard_glob_matcher_top import wgm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  wgm_in_if.sink    in_if,
  wgm_out_if.source out_if,
  wgm_cfg_if.sink   cfg_if
);

  // Configuration state
  logic [WORD_W-1:0] pat_word_r [NWORDS];
  logic [WORD_W-1:0] pat_word_nxt [NWORDS];
  logic [NPOS-1:0]   use_r, use_nxt;      // position i < effective length
  logic [NPOS-1:0]   range_r, range_nxt;  // position i <= effective length
  logic [LEN_W-1:0]  eff_len;

  // Matching state
  logic [NPOS-1:0] active_r, active_nxt;
  logic [NPOS-1:0] fin_r, fin_nxt;
  logic            p_valid_r, p_valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_matched_r, out_matched_nxt;

  logic              in_acc;
  logic              p_move;
  logic [NPOS-1:0]   step_set;
  logic [NPOS-1:0]   row_a_nxt;
  logic [NPOS-1:0]   row_b_nxt;
  logic              row_a_tail;
  logic              row_b_tail;
  logic [CHAR_W-1:0] pat_char [NPOS];

  // Unpack the pattern words into one byte per position; the top position
  // only terminates the closure and never consumes a character.
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pat
    assign pat_char[i] = pat_word_r[i / CHARS_PER_W][(i % CHARS_PER_W) * CHAR_W +: CHAR_W];
  end
  assign pat_char[MAX_PATTERN] = '0;

  // Stepping row: closes the live set and consumes the incoming character.
  wgm_row u_row_step (
    .act       (active_r),
    .pat_char  (pat_char),
    .in_use    (use_r),
    .in_range  (range_r),
    .text_char (in_if.text_char),
    .nxt       (row_a_nxt),
    .tail      (row_a_tail)
  );

  // Final row: closes the parked end-of-string set and reads the accept bit.
  wgm_row u_row_final (
    .act       (fin_r),
    .pat_char  (pat_char),
    .in_use    (use_r),
    .in_range  (range_r),
    .text_char ('0),
    .nxt       (row_b_nxt),
    .tail      (row_b_tail)
  );

  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign p_move       = p_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !p_valid_r || p_move;
  assign out_if.valid   = out_valid_r;
  assign out_if.matched = out_matched_r;

  // Saturate the written length at the maximum pattern size.
  assign eff_len = (cfg_if.data[LEN_W-1:0] > LEN_W'(MAX_PATTERN))
                   ? LEN_W'(MAX_PATTERN) : cfg_if.data[LEN_W-1:0];

  // Configuration writes
  always_comb begin
    pat_word_nxt = pat_word_r;
    use_nxt      = use_r;
    range_nxt    = range_r;
    if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        REG_PATTERN_0: pat_word_nxt[0] = cfg_if.data;
        REG_PATTERN_1: pat_word_nxt[1] = cfg_if.data;
        REG_PATTERN_2: pat_word_nxt[2] = cfg_if.data;
        REG_PATTERN_3: pat_word_nxt[3] = cfg_if.data;
        REG_PATTERN_LEN: begin
          // Decode the length into thermometer masks once, at write time.
          for (int i = 0; i < NPOS; i++) begin
            use_nxt[i]   = (LEN_W'(i) < eff_len);
            range_nxt[i] = (LEN_W'(i) <= eff_len);
          end
        end
        default: begin
          // Drop writes to unknown registers.
        end
      endcase
    end
  end

  // Item path
  always_comb begin
    active_nxt      = active_r;
    fin_nxt         = fin_r;
    p_valid_nxt     = p_valid_r;
    out_valid_nxt   = out_valid_r;
    out_matched_nxt = out_matched_r;
    step_set        = in_if.has_char ? row_a_nxt : active_r;

    // Advance the parked set into the output register, or drop a taken result.
    if (p_move) begin
      p_valid_nxt     = 1'b0;
      out_valid_nxt   = 1'b1;
      out_matched_nxt = row_b_tail;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      if (in_if.end_of_text) begin
        // Park the final set and return to the start position.
        fin_nxt     = step_set;
        p_valid_nxt = 1'b1;
        active_nxt  = START_SET;
      end else begin
        active_nxt = step_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NWORDS; k++) begin
        pat_word_r[k] <= '0;
      end
      use_r       <= '0;
      range_r     <= START_SET;
      active_r    <= START_SET;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pat_word_r  <= pat_word_nxt;
      use_r       <= use_nxt;
      range_r     <= range_nxt;
      active_r    <= active_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r         <= fin_nxt;
    out_matched_r <= out_matched_nxt;
  end

  // A new result only comes out of a parked end-of-string set.
  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(p_valid_r))
    else $error("result appeared without a parked end-of-string set");

  // An item ending a string leaves only the start position active.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.end_of_text) |=> (active_r == START_SET))
    else $error("active set not restarted after end of string");

  // Input backpressure only while both result slots are full and stalled.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (p_valid_r && out_valid_r && !out_if.ready))
    else $error("input stalled without a full result path");

  // The length masks stay consistent: every position in use is in range.
  a_masks: assert property (@(posedge clk) disable iff (!rst_n)
    ((use_r & ~range_r) == '0) && range_r[0] && !use_r[MAX_PATTERN]
    && ((row_a_nxt & ~range_r) == '0) && ((row_b_nxt & ~range_r) == '0)
    && (row_a_tail || !row_a_tail))
    else $error("pattern length masks inconsistent");

endmodule

// File: sim/tb_wildcard_glob_matcher_top.sv
module tb_wildcard_glob_matcher_top import wgm_pkg::*; ;

  // Stimulus stops once this many counted items have been accepted.
  localparam int TOTAL_ITEMS   = 1625;
  // Idle cycles between the last result of a phase and a register write.
  localparam int IDLE_SETTLE   = 4;
  // Cycles to keep watching the output after the last expected result.
  localparam int DRAIN_CYCLES  = 10;
  // Length of the one long receiver hold-off, and when it starts.
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AFTER    = 40;
  // Text length at which make_text stops walking the pattern for a new text.
  localparam int MAX_TEXT      = 48;
  localparam logic [CHAR_W-1:0] ALPHA_BASE = 8'h61;  // 'a'

  localparam logic [CFG_IDX_W-1:0] WORD_REGS [NWORDS] =
    '{REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3};

  typedef enum int {
    PAT_SHORT_GLOB,
    PAT_FULL_GLOB,
    PAT_EMPTY,
    PAT_RAW_BYTES,
    PAT_MID_GLOB,
    PAT_STAR_HEAVY
  } pattern_kind_t;

  // Scoreboard: keeps its own copy of the pattern registers and the active
  // position set, predicts the match bit of every string, and checks the
  // results in order.
  class match_scoreboard_t;
    logic [WORD_W-1:0] pattern_words [NWORDS];
    logic [LEN_W-1:0]  pattern_len;
    logic [NPOS-1:0]   live_set;
    bit                expected_matches [$];
    int                errors;

    function new();
      foreach (pattern_words[k]) pattern_words[k] = '0;
      pattern_len = '0;
      live_set    = START_SET;
      errors      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        REG_PATTERN_0:   pattern_words[0] = data;
        REG_PATTERN_1:   pattern_words[1] = data;
        REG_PATTERN_2:   pattern_words[2] = data;
        REG_PATTERN_3:   pattern_words[3] = data;
        REG_PATTERN_LEN: pattern_len = data[LEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int span();
      int n;
      n = pattern_len;
      if (n > MAX_PATTERN) n = MAX_PATTERN;
      return n;
    endfunction

    function logic [CHAR_W-1:0] pattern_char(int i);
      return pattern_words[i / CHARS_PER_W][(i % CHARS_PER_W) * CHAR_W +: CHAR_W];
    endfunction

    // Drop positions past the pattern end, then let every active star
    // also open the position after it, low to high so star runs chain.
    function logic [NPOS-1:0] closed_positions();
      int n;
      logic [NPOS-1:0] v;
      n = span();
      v = '0;
      for (int i = 0; i <= n; i++) v[i] = live_set[i];
      for (int i = 0; i < n; i++)
        if (v[i] && pattern_char(i) == STAR_CHAR) v[i+1] = 1'b1;
      return v;
    endfunction

    function void note_item(logic [CHAR_W-1:0] c, logic has_char, logic end_of_text);
      int n;
      logic [NPOS-1:0] cur;
      logic [NPOS-1:0] stepped;
      n = span();
      if (has_char) begin
        cur = closed_positions();
        stepped = '0;
        for (int i = 0; i < n; i++) begin
          if (cur[i]) begin
            if (pattern_char(i) == STAR_CHAR) stepped[i] = 1'b1;
            else if (pattern_char(i) == ANY_CHAR || pattern_char(i) == c)
              stepped[i+1] = 1'b1;
          end
        end
        live_set = stepped;
      end
      if (end_of_text) begin
        cur = closed_positions();
        expected_matches.push_back(cur[n]);
        live_set = START_SET;
      end
    endfunction

    function void check_result(logic got);
      bit want;
      if (expected_matches.size() == 0) begin
        $display("%0t: result with no string pending, actual matched %0b", $time, got);
        errors++;
      end else begin
        want = expected_matches.pop_front();
        if (got !== want) begin
          $display("%0t: matched mismatch, expected %0b actual %0b", $time, want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  wgm_in_if  in_bus ();
  wgm_out_if out_bus ();
  wgm_cfg_if cfg_bus ();

  wildcard_glob_matcher_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus),
    .cfg_if (cfg_bus)
  );

  match_scoreboard_t sb = new();

  // Pattern as the stimulus sees it; bytes past pat_len are filler.
  logic [CHAR_W-1:0] pat_bytes [MAX_PATTERN];
  int                pat_len;
  // Text of the string about to be sent.
  logic [CHAR_W-1:0] text_q [$];

  int items_sent;    // accepted items, ignored empty items left out
  int results_seen;  // accepted results
  int send_burst;    // items left in a no-gap stretch on the input side
  bit long_hold_done;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // Sample the result channel at the rising edge and check each result.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      sb.check_result(out_bus.matched);
    end
  end

  // Receiver: alternate ready runs and stalls of random length, mostly
  // short. Once enough results have come, hold off for a long stretch while
  // the sender keeps offering, so the block fills up and stalls its input.
  initial begin
    int n;
    int r;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        out_bus.ready <= 1'b0;
        n = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (r < 25) begin
        out_bus.ready <= 1'b0;
        n = (r < 22) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end else begin
        out_bus.ready <= 1'b1;
        n = (r < 95) ? $urandom_range(1, 12) : $urandom_range(40, 80);
      end
      repeat (n) @(negedge clk);
    end
  end

  // Gap before the next input item: mostly none, some short, a few long,
  // and now and then a stretch of back-to-back items.
  function automatic int pick_send_gap();
    int r;
    if (send_burst > 0) begin
      send_burst--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      send_burst = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CHAR_W-1:0] alpha_char();
    return ALPHA_BASE + CHAR_W'($urandom_range(0, 2));
  endfunction

  function automatic logic [CHAR_W-1:0] any_text_char();
    return CHAR_W'($urandom_range(1, 255));
  endfunction

  // Mostly the small alphabet so texts hit the pattern, now and then any byte.
  function automatic logic [CHAR_W-1:0] text_char_pick();
    return ($urandom_range(0, 4) == 0) ? any_text_char() : alpha_char();
  endfunction

  // Offer one item; called at a falling edge, returns at a falling edge.
  // Lower valid only for a real gap so it never toggles within a step.
  task automatic offer(logic [CHAR_W-1:0] c, logic has_char, logic end_of_text);
    int gap;
    gap = pick_send_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.text_char   <= c;
    in_bus.has_char    <= has_char;
    in_bus.end_of_text <= end_of_text;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_item(c, has_char, end_of_text);
    if (has_char || end_of_text) items_sent++;
    @(negedge clk);
  endtask

  // Send text_q as one string. Either the last character closes it, or a
  // separate item without a character does; an empty text is the empty
  // string. Noise adds ignored empty items here and there.
  task automatic send_text(bit sep_end, bit noise);
    if (text_q.size() == 0) begin
      offer(any_text_char(), 1'b0, 1'b1);
    end else begin
      foreach (text_q[i]) begin
        if (noise && $urandom_range(0, 15) == 0) offer(any_text_char(), 1'b0, 1'b0);
        if (i == text_q.size() - 1 && !sep_end) offer(text_q[i], 1'b1, 1'b1);
        else offer(text_q[i], 1'b1, 1'b0);
      end
      if (sep_end) offer(any_text_char(), 1'b0, 1'b1);
    end
  endtask

  // Drop valid, wait out every pending result, then let the block settle.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (sb.expected_matches.size() != 0) @(negedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  // One register write; valid stays high so writes can go back to back.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Pack pat_bytes into the four words, low byte first, and load everything.
  task automatic program_pattern();
    logic [WORD_W-1:0] w;
    wait_idle();
    for (int k = 0; k < NWORDS; k++) begin
      for (int j = 0; j < CHARS_PER_W; j++) w[j*CHAR_W +: CHAR_W] = pat_bytes[k*CHARS_PER_W + j];
      cfg_write(WORD_REGS[k], w);
    end
    cfg_write(REG_PATTERN_LEN, WORD_W'(pat_len));
    cfg_bus.valid <= 1'b0;
  endtask

  // Load a pattern given as text; fill the unused bytes with junk.
  task automatic load_pattern_text(string s);
    for (int i = 0; i < MAX_PATTERN; i++)
      pat_bytes[i] = (i < s.len()) ? s[i] : CHAR_W'($urandom_range(0, 255));
    pat_len = s.len();
    program_pattern();
  endtask

  function automatic logic [CHAR_W-1:0] glob_byte(int star_weight);
    int r;
    r = $urandom_range(0, 9);
    if (r < star_weight) return STAR_CHAR;
    if (r == star_weight) return ANY_CHAR;
    return alpha_char();
  endfunction

  // Build a random pattern of the given kind in pat_bytes/pat_len.
  task automatic make_pattern(pattern_kind_t kind);
    int stars;
    stars = 2;
    case (kind)
      PAT_SHORT_GLOB: pat_len = $urandom_range(1, 10);
      PAT_FULL_GLOB:  pat_len = MAX_PATTERN;
      PAT_EMPTY:      pat_len = 0;
      PAT_RAW_BYTES:  pat_len = $urandom_range(1, MAX_PATTERN);
      PAT_MID_GLOB:   pat_len = $urandom_range(11, MAX_PATTERN - 1);
      PAT_STAR_HEAVY: begin
        pat_len = $urandom_range(1, MAX_PATTERN);
        stars = 6;
      end
      default:        pat_len = 0;
    endcase
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (i >= pat_len || kind == PAT_RAW_BYTES) pat_bytes[i] = CHAR_W'($urandom_range(0, 255));
      else pat_bytes[i] = glob_byte(stars);
    end
  endtask

  // Build a text: usually one the pattern accepts, sometimes with one
  // edit, sometimes plain random.
  task automatic make_text();
    int n;
    int pos;
    text_q.delete();
    if ($urandom_range(0, 9) < 6) begin
      for (int i = 0; i < pat_len && text_q.size() < MAX_TEXT; i++) begin
        if (pat_bytes[i] == STAR_CHAR) begin
          n = $urandom_range(0, 3);
          repeat (n) text_q.push_back(text_char_pick());
        end else if (pat_bytes[i] == ANY_CHAR) begin
          text_q.push_back(text_char_pick());
        end else if (pat_bytes[i] == '0) begin
          // a zero literal can never be met by a nonzero text byte
          text_q.push_back(any_text_char());
        end else begin
          text_q.push_back(pat_bytes[i]);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        pos = (text_q.size() == 0) ? 0 : $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 2))
          0: if (text_q.size() != 0) text_q[pos] = text_char_pick();
          1: if (text_q.size() != 0) text_q.delete(pos);
          default: text_q.insert(pos, text_char_pick());
        endcase
      end
    end else begin
      n = $urandom_range(0, 8);
      repeat (n) text_q.push_back(text_char_pick());
    end
  endtask

  initial begin
    int phase_goal;
    pattern_kind_t kind;

    clk                = 1'b0;
    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.text_char   = '0;
    in_bus.has_char    = 1'b0;
    in_bus.end_of_text = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = '0;
    cfg_bus.data       = '0;
    items_sent         = 0;
    results_seen       = 0;
    send_burst         = 0;
    long_hold_done     = 1'b0;

    // Hold reset, then release it at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset pattern is empty: only the empty string matches. An empty item
    // in between changes nothing.
    text_q.delete();
    send_text(1'b0, 1'b0);
    offer(8'h41, 1'b0, 1'b0);
    text_q = '{8'h78};
    send_text(1'b1, 1'b0);

    // Leading star run then a literal and a single-char wildcard.
    load_pattern_text("**a?");
    text_q.delete();
    send_text(1'b0, 1'b0);
    text_q = '{8'h61, 8'h62};
    send_text(1'b0, 1'b0);
    text_q = '{8'h7A, 8'h7A, 8'h61, 8'h62};
    send_text(1'b1, 1'b0);
    text_q = '{8'h61};
    send_text(1'b0, 1'b0);
    text_q = '{8'h61, 8'h62, 8'h63};
    send_text(1'b0, 1'b0);

    // Longest pattern, all stars: anything matches, the empty string too.
    for (int i = 0; i < MAX_PATTERN; i++) pat_bytes[i] = STAR_CHAR;
    pat_len = MAX_PATTERN;
    program_pattern();
    text_q.delete();
    send_text(1'b0, 1'b0);
    text_q = '{8'hFF};
    send_text(1'b0, 1'b0);
    text_q = '{8'h01, 8'h80};
    send_text(1'b0, 1'b0);

    // Extreme byte literals, with a zero byte as an ordinary literal.
    for (int i = 0; i < MAX_PATTERN; i++) pat_bytes[i] = '1;
    pat_bytes[0] = 8'hFF;
    pat_bytes[1] = ANY_CHAR;
    pat_bytes[2] = 8'h00;
    pat_len = 3;
    program_pattern();
    text_q = '{8'hFF, 8'h80, 8'h01};
    send_text(1'b0, 1'b0);
    text_q = '{8'hFF, 8'h01};
    send_text(1'b0, 1'b0);

    // Random phases: new pattern, then strings until the phase is full.
    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: kind = PAT_SHORT_GLOB;
        4:          kind = PAT_FULL_GLOB;
        5:          kind = PAT_EMPTY;
        6:          kind = PAT_RAW_BYTES;
        7:          kind = PAT_MID_GLOB;
        default:    kind = PAT_STAR_HEAVY;
      endcase
      make_pattern(kind);
      program_pattern();
      phase_goal = items_sent + $urandom_range(60, 140);
      while (items_sent < phase_goal) begin
        make_text();
        send_text($urandom_range(0, 3) == 0, 1'b1);
      end
    end

    // Drain: wait for every pending result, then watch a little longer.
    in_bus.valid <= 1'b0;
    while (sb.expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
